[design/rdzr_pkg.sv]
// shared widths and constants for the radial dead zone rescale unit
package rdzr_pkg;

   localparam int STICK_W        = 9;
   localparam int SCALE_W        = 16;
   localparam int DZ_W           = 8;
   localparam int FRAC_W         = 8;
   localparam int FULL_SCALE_DEF = 180;

   localparam logic [DZ_W-1:0] DZ_RESET = 8'd25;

endpackage

[design/rdzr_root_pipe.sv]
// pipelined integer square root, one root bit per stage
module rdzr_root_pipe #(
   parameter int RAD_W  = 34,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [RAD_W-1:0]     in_radicand,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int NS     = ROOT_W;

   logic              v_ff    [NS];
   logic [REM_W-1:0]  rem_ff  [NS];
   logic [ROOT_W-1:0] root_ff [NS];
   logic [RAD_W-1:0]  rad_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];

   logic              src_v    [NS];
   logic [REM_W-1:0]  src_rem  [NS];
   logic [ROOT_W-1:0] src_root [NS];
   logic [RAD_W-1:0]  src_rad  [NS];
   logic [SIDE_W-1:0] src_side [NS];

   logic [REM_W-1:0]  rem_in  [NS];
   logic [ROOT_W-1:0] root_in [NS];
   logic [RAD_W-1:0]  rad_in  [NS];
   logic              rdy     [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (g == 0) begin : g_first
         assign src_v[g]    = in_valid;
         assign src_rem[g]  = '0;
         assign src_root[g] = '0;
         assign src_rad[g]  = in_radicand;
         assign src_side[g] = in_side;
      end else begin : g_next
         assign src_v[g]    = v_ff[g-1];
         assign src_rem[g]  = rem_ff[g-1];
         assign src_root[g] = root_ff[g-1];
         assign src_rad[g]  = rad_ff[g-1];
         assign src_side[g] = side_ff[g-1];
      end

      // a stage moves when it is empty or the one after it moves
      if (g == NS - 1) begin : g_last
         assign rdy[g] = !v_ff[g] || out_ready;
      end else begin : g_mid
         assign rdy[g] = !v_ff[g] || rdy[g+1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign cur        = {src_rem[g][REM_W-3:0], src_rad[g][RAD_W-1 -: 2]};
      assign trial      = {src_root[g], 2'b01};
      assign ge         = cur >= trial;
      assign rem_in[g]  = ge ? cur - trial : cur;
      assign root_in[g] = {src_root[g][ROOT_W-2:0], ge};
      assign rad_in[g]  = src_rad[g] << 2;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            v_ff[i] <= src_v[i];
         end
         if (rdy[i]) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
            side_ff[i] <= src_side[i];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

   // final remainder n - r*r never exceeds 2r, else the root is too small
   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> rem_ff[NS-1] <= REM_W'({root_ff[NS-1], 1'b0}))
      else $error("root remainder exceeds twice the root");

   a_root_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_ff[0])
      else $error("accepted radicand did not enter first stage");

endmodule

[design/rdzr_div_pipe.sv]
// pipelined restoring divider, two numerator lanes over one shared divisor
module rdzr_div_pipe #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 25,
   parameter int QUO_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [NUM_W-1:0]   in_num_x,
   input  logic [NUM_W-1:0]   in_num_y,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [QUO_W-1:0]   out_quo_x,
   output logic [QUO_W-1:0]   out_quo_y,
   output logic [SIDE_W-1:0]  out_side
);

   localparam int NS = QUO_W;

   logic              v_ff    [NS];
   logic [NUM_W-1:0]  rx_ff   [NS];
   logic [NUM_W-1:0]  ry_ff   [NS];
   logic [QUO_W-1:0]  qx_ff   [NS];
   logic [QUO_W-1:0]  qy_ff   [NS];
   logic [DEN_W-1:0]  den_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];

   logic              src_v    [NS];
   logic [NUM_W-1:0]  src_rx   [NS];
   logic [NUM_W-1:0]  src_ry   [NS];
   logic [QUO_W-1:0]  src_qx   [NS];
   logic [QUO_W-1:0]  src_qy   [NS];
   logic [DEN_W-1:0]  src_den  [NS];
   logic [SIDE_W-1:0] src_side [NS];

   logic [NUM_W-1:0]  rx_in [NS];
   logic [NUM_W-1:0]  ry_in [NS];
   logic [QUO_W-1:0]  qx_in [NS];
   logic [QUO_W-1:0]  qy_in [NS];
   logic              rdy   [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      localparam int SH = QUO_W - 1 - g;
      logic [NUM_W-1:0] den_ext;
      logic             ge_x;
      logic             ge_y;

      if (g == 0) begin : g_first
         assign src_v[g]    = in_valid;
         assign src_rx[g]   = in_num_x;
         assign src_ry[g]   = in_num_y;
         assign src_qx[g]   = '0;
         assign src_qy[g]   = '0;
         assign src_den[g]  = in_den;
         assign src_side[g] = in_side;
      end else begin : g_next
         assign src_v[g]    = v_ff[g-1];
         assign src_rx[g]   = rx_ff[g-1];
         assign src_ry[g]   = ry_ff[g-1];
         assign src_qx[g]   = qx_ff[g-1];
         assign src_qy[g]   = qy_ff[g-1];
         assign src_den[g]  = den_ff[g-1];
         assign src_side[g] = side_ff[g-1];
      end

      if (g == NS - 1) begin : g_last
         assign rdy[g] = !v_ff[g] || out_ready;
      end else begin : g_mid
         assign rdy[g] = !v_ff[g] || rdy[g+1];
      end

      // rem >= den << SH is the same test as (rem >> SH) >= den
      assign den_ext  = NUM_W'(src_den[g]);
      assign ge_x     = (src_rx[g] >> SH) >= den_ext;
      assign ge_y     = (src_ry[g] >> SH) >= den_ext;
      assign rx_in[g] = ge_x ? src_rx[g] - (den_ext << SH) : src_rx[g];
      assign ry_in[g] = ge_y ? src_ry[g] - (den_ext << SH) : src_ry[g];
      assign qx_in[g] = {src_qx[g][QUO_W-2:0], ge_x};
      assign qy_in[g] = {src_qy[g][QUO_W-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            v_ff[i] <= src_v[i];
         end
         if (rdy[i]) begin
            rx_ff[i]   <= rx_in[i];
            ry_ff[i]   <= ry_in[i];
            qx_ff[i]   <= qx_in[i];
            qy_ff[i]   <= qy_in[i];
            den_ff[i]  <= src_den[i];
            side_ff[i] <= src_side[i];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_quo_x = qx_ff[NS-1];
   assign out_quo_y = qy_ff[NS-1];
   assign out_side  = side_ff[NS-1];

   // a finished quotient leaves a remainder below the divisor
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid && (den_ff[NS-1] != '0) |->
         (rx_ff[NS-1] < NUM_W'(den_ff[NS-1])) && (ry_ff[NS-1] < NUM_W'(den_ff[NS-1])))
      else $error("divider remainder not below divisor");

endmodule

[design/radial_dead_zone_rescale_unit.sv]
// Radial dead zone rescale of a signed stick sample. Each beat (x, y) gets its
// magnitude as a root with 8 fraction bits; below the dead zone radius, or with
// a dead zone at or above full scale, both outputs are zero, otherwise each axis
// becomes |v|*FULL_SCALE*(mag - dz*256) / (mag*(FULL_SCALE - dz)), truncated
// toward zero, signed and saturated to 16 bits. The pipeline takes one sample
// per cycle while rsp_ready does not stall it; a sample passes one square stage,
// one root bit per stage, one multiply stage, one quotient bit per stage and
// the output register. The dead zone register reads 25 after reset; the user
// must write it through csr_ only while no sample is in flight, which the block
// itself does not enforce; csr_ready is always high.
module radial_dead_zone_rescale_unit import rdzr_pkg::*; #(
   parameter int unsigned FULL_SCALE = FULL_SCALE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [STICK_W-1:0] req_stick_x,
   input  logic signed [STICK_W-1:0] req_stick_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SCALE_W-1:0] rsp_scaled_x,
   output logic signed [SCALE_W-1:0] rsp_scaled_y,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [DZ_W-1:0]           csr_dead_zone
);

   localparam int FS_W    = $clog2(FULL_SCALE + 1);
   localparam int ABS_W   = STICK_W;
   localparam int SQ_W    = 2 * STICK_W;
   localparam int RAD_W   = SQ_W + 2 * FRAC_W;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int AFS_W   = ABS_W + FS_W;
   localparam int NUM_W   = AFS_W + ROOT_W;
   localparam int DEN_W   = ROOT_W + FS_W;
   localparam int QUO_W   = AFS_W;
   localparam int CMP_W   = (QUO_W > SCALE_W ? QUO_W : SCALE_W) + 1;
   localparam int SIDE1_W = 2 * AFS_W + 2 + DZ_W;
   localparam int SIDE2_W = 3;

   localparam logic [FS_W-1:0]    FS_F    = FS_W'(FULL_SCALE);
   localparam logic [DZ_W-1:0]    FS_DZ   = DZ_W'(FULL_SCALE);
   localparam logic [CMP_W-1:0]   POS_LIM = CMP_W'((1 << (SCALE_W - 1)) - 1);
   localparam logic [CMP_W-1:0]   NEG_LIM = CMP_W'(1 << (SCALE_W - 1));
   localparam logic [SCALE_W-1:0] MAX_OUT = {1'b0, {(SCALE_W - 1){1'b1}}};
   localparam logic [SCALE_W-1:0] MIN_OUT = {1'b1, {(SCALE_W - 1){1'b0}}};

   typedef struct packed {
      logic [AFS_W-1:0] afs_x;
      logic [AFS_W-1:0] afs_y;
      logic             neg_x;
      logic             neg_y;
      logic [DZ_W-1:0]  dz;
   } root_side_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic kill;
   } div_side_type;

   function automatic logic [SCALE_W-1:0] sat_axis(input logic [QUO_W-1:0] q,
                                                   input logic neg);
      logic [CMP_W-1:0] qe;
      logic [CMP_W-1:0] nq;
      qe = CMP_W'(q);
      nq = '0 - qe;
      if (neg) begin
         sat_axis = (qe > NEG_LIM) ? MIN_OUT : nq[SCALE_W-1:0];
      end else begin
         sat_axis = (qe > POS_LIM) ? MAX_OUT : qe[SCALE_W-1:0];
      end
   endfunction

   // configuration
   logic [DZ_W-1:0] dead_zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DZ_RESET;
      end else if (csr_valid) begin
         dead_zone_ff <= csr_dead_zone;
      end
   end

   assign csr_ready = 1'b1;

   // stage 1: absolute values, sum of squares, |v| * full scale
   logic [ABS_W-1:0] ax_in;
   logic [ABS_W-1:0] ay_in;
   logic [SQ_W-1:0]  sq_in;
   root_side_type    s1_side_in;

   logic             s1_v_ff;
   logic [SQ_W-1:0]  s1_sq_ff;
   root_side_type    s1_side_ff;
   logic             rdy1;
   logic             rt_in_ready;

   always_comb begin
      ax_in = req_stick_x[STICK_W-1] ? ABS_W'(-req_stick_x) : ABS_W'(req_stick_x);
      ay_in = req_stick_y[STICK_W-1] ? ABS_W'(-req_stick_y) : ABS_W'(req_stick_y);
      sq_in = SQ_W'(ax_in) * SQ_W'(ax_in) + SQ_W'(ay_in) * SQ_W'(ay_in);
      s1_side_in.afs_x = AFS_W'(ax_in) * AFS_W'(FULL_SCALE);
      s1_side_in.afs_y = AFS_W'(ay_in) * AFS_W'(FULL_SCALE);
      s1_side_in.neg_x = req_stick_x[STICK_W-1];
      s1_side_in.neg_y = req_stick_y[STICK_W-1];
      s1_side_in.dz    = dead_zone_ff;
   end

   assign rdy1      = !s1_v_ff || rt_in_ready;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= req_valid;
      end
      if (rdy1) begin
         s1_sq_ff   <= sq_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // magnitude with 8 fraction bits
   logic              rt_v;
   logic [ROOT_W-1:0] rt_root;
   root_side_type     rt_side;
   logic              rdy3;

   rdzr_root_pipe #(
      .RAD_W  (RAD_W),
      .SIDE_W (SIDE1_W)
   ) u_root (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_v_ff),
      .in_ready    (rt_in_ready),
      .in_radicand (RAD_W'(s1_sq_ff) << (2 * FRAC_W)),
      .in_side     (s1_side_ff),
      .out_valid   (rt_v),
      .out_ready   (rdy3),
      .out_root    (rt_root),
      .out_side    (rt_side)
   );

   // stage 3: dead zone test, numerators and shared divisor
   logic [ROOT_W-1:0] dzf_in;
   logic [ROOT_W-1:0] diff_in;
   logic [FS_W-1:0]   fsd_in;
   div_side_type      s3_side_in;

   logic              s3_v_ff;
   logic [NUM_W-1:0]  s3_num_x_ff;
   logic [NUM_W-1:0]  s3_num_y_ff;
   logic [DEN_W-1:0]  s3_den_ff;
   div_side_type      s3_side_ff;
   logic              dv_in_ready;

   always_comb begin
      dzf_in  = ROOT_W'(rt_side.dz) << FRAC_W;
      diff_in = rt_root - dzf_in;
      fsd_in  = FS_F - rt_side.dz[FS_W-1:0];
      s3_side_in.neg_x = rt_side.neg_x;
      s3_side_in.neg_y = rt_side.neg_y;
      s3_side_in.kill  = (rt_side.dz >= FS_DZ) || (rt_root == '0) || (rt_root < dzf_in);
   end

   assign rdy3 = !s3_v_ff || dv_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (rdy3) begin
         s3_v_ff <= rt_v;
      end
      if (rdy3) begin
         s3_num_x_ff <= NUM_W'(rt_side.afs_x) * NUM_W'(diff_in);
         s3_num_y_ff <= NUM_W'(rt_side.afs_y) * NUM_W'(diff_in);
         s3_den_ff   <= DEN_W'(rt_root) * DEN_W'(fsd_in);
         s3_side_ff  <= s3_side_in;
      end
   end

   // quotients
   logic             dv_v;
   logic [QUO_W-1:0] dv_quo_x;
   logic [QUO_W-1:0] dv_quo_y;
   div_side_type     dv_side;
   logic             rdy5;

   rdzr_div_pipe #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE2_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (dv_in_ready),
      .in_num_x  (s3_num_x_ff),
      .in_num_y  (s3_num_y_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_v),
      .out_ready (rdy5),
      .out_quo_x (dv_quo_x),
      .out_quo_y (dv_quo_y),
      .out_side  (dv_side)
   );

   // stage 5: sign, saturation, output register
   logic               out_v_ff;
   logic [SCALE_W-1:0] out_x_ff;
   logic [SCALE_W-1:0] out_y_ff;

   assign rdy5 = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy5) begin
         out_v_ff <= dv_v;
      end
      if (rdy5) begin
         out_x_ff <= dv_side.kill ? '0 : sat_axis(dv_quo_x, dv_side.neg_x);
         out_y_ff <= dv_side.kill ? '0 : sat_axis(dv_quo_y, dv_side.neg_y);
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_scaled_x = out_x_ff;
   assign rsp_scaled_y = out_y_ff;

   // a draining output never holds back the input side
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_v_ff)
      else $error("accepted sample lost at first stage");

   // live samples always carry a nonzero divisor
   a_live_den: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !s3_side_ff.kill |-> s3_den_ff != '0)
      else $error("zero divisor on a live sample");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the radial dead zone rescale unit
module tb_top import rdzr_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_SCALE  = FULL_SCALE_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_TAIL  = 48;
   localparam int PROBE_N     = 25;
   localparam int PHASE_N     = 7;
   localparam int PHASE_BEATS = 150;

   typedef struct {
      logic signed [SCALE_W-1:0] x;
      logic signed [SCALE_W-1:0] y;
   } scaled_pair_type;

   typedef struct packed {
      logic [DZ_W-1:0]    dz;
      logic [STICK_W-1:0] x;
      logic [STICK_W-1:0] y;
      logic               known;
      logic [SCALE_W-1:0] ex;
      logic [SCALE_W-1:0] ey;
   } probe_row_type;

   // known rows carry a result that can be read off directly, the rest use the predictor
   probe_row_type probe_tab [PROBE_N] = '{
      '{8'd25,  9'sd0,    9'sd0,    1'b1, 16'sd0,    16'sd0},
      '{8'd25,  9'sd24,   9'sd0,    1'b1, 16'sd0,    16'sd0},
      '{8'd25,  9'sd25,   9'sd0,    1'b1, 16'sd0,    16'sd0},
      '{8'd25,  9'sd26,   9'sd0,    1'b0, 16'sd0,    16'sd0},
      '{8'd25,  9'sd0,   -9'sd25,   1'b1, 16'sd0,    16'sd0},
      '{8'd25, -9'sd256, -9'sd256,  1'b0, 16'sd0,    16'sd0},
      '{8'd25,  9'sd255,  9'sd255,  1'b0, 16'sd0,    16'sd0},
      '{8'd25, -9'sd256,  9'sd255,  1'b0, 16'sd0,    16'sd0},
      '{8'd25,  9'sd255, -9'sd256,  1'b0, 16'sd0,    16'sd0},
      '{8'd25,  9'sd17,  -9'sd18,   1'b0, 16'sd0,    16'sd0},
      '{8'd0,   9'sd0,    9'sd0,    1'b1, 16'sd0,    16'sd0},
      '{8'd0,   9'sd255,  9'sd0,    1'b1, 16'sd255,  16'sd0},
      '{8'd0,  -9'sd256,  9'sd0,    1'b1, -16'sd256, 16'sd0},
      '{8'd0,   9'sd0,    9'sd1,    1'b1, 16'sd0,    16'sd1},
      '{8'd0,  -9'sd1,   -9'sd1,    1'b0, 16'sd0,    16'sd0},
      '{8'd0,  -9'sd256, -9'sd256,  1'b0, 16'sd0,    16'sd0},
      '{8'd179, 9'sd255,  9'sd255,  1'b0, 16'sd0,    16'sd0},
      '{8'd179,-9'sd256, -9'sd256,  1'b0, 16'sd0,    16'sd0},
      '{8'd179, 9'sd179,  9'sd0,    1'b1, 16'sd0,    16'sd0},
      '{8'd179,-9'sd100,  9'sd100,  1'b0, 16'sd0,    16'sd0},
      '{8'd180, 9'sd255,  9'sd255,  1'b1, 16'sd0,    16'sd0},
      '{8'd180,-9'sd256, -9'sd256,  1'b1, 16'sd0,    16'sd0},
      '{8'd255,-9'sd256,  9'sd255,  1'b1, 16'sd0,    16'sd0},
      '{8'd255, 9'sd255, -9'sd256,  1'b1, 16'sd0,    16'sd0},
      '{8'd255, 9'sd0,    9'sd0,    1'b1, 16'sd0,    16'sd0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [STICK_W-1:0] req_stick_x = '0;
   logic signed [STICK_W-1:0] req_stick_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic signed [SCALE_W-1:0] rsp_scaled_x;
   logic signed [SCALE_W-1:0] rsp_scaled_y;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [DZ_W-1:0]           csr_dead_zone = '0;

   scaled_pair_type scaled_due_q [$];
   logic [DZ_W-1:0] active_dz = DZ_RESET;
   bit              sender_up = 1'b0;
   int              tx_run = 0;
   bit              tx_calm = 1'b0;
   int              rx_run = 0;
   bit              rx_calm = 1'b0;
   int              rx_left = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   radial_dead_zone_rescale_unit #(
      .FULL_SCALE(FULL_SCALE)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_stick_x  (req_stick_x),
      .req_stick_y  (req_stick_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_scaled_x (rsp_scaled_x),
      .rsp_scaled_y (rsp_scaled_y),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_dead_zone(csr_dead_zone)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL radial_dead_zone_rescale_unit");
         $finish;
      end
   end

   // idle cycles before a beat, with stretches of back-to-back beats
   function automatic int draw_idle(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(1, 40);
         calm = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // floor of the square root, one result bit at a time from the top
   function automatic logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [SCALE_W-1:0] shrink_axis(longint v, logic [63:0] mag,
                                                              logic [DZ_W-1:0] dz);
      logic [63:0] av;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      logic [63:0] neg;
      av  = (v < 0) ? -v : v;
      num = av * FULL_SCALE * (mag - {dz, 8'd0});
      den = mag * (FULL_SCALE - dz);
      quo = num / den;
      if (v < 0) begin
         if (quo > 64'd32768)
            return -16'sd32768;
         neg = 64'd0 - quo;
         return neg[SCALE_W-1:0];
      end
      if (quo > 64'd32767)
         return 16'sd32767;
      return quo[SCALE_W-1:0];
   endfunction

   function automatic scaled_pair_type rescale_sample(logic signed [STICK_W-1:0] sx,
                                                      logic signed [STICK_W-1:0] sy,
                                                      logic [DZ_W-1:0] dz);
      scaled_pair_type res;
      longint          vx;
      longint          vy;
      logic [63:0]     sq;
      logic [63:0]     mag;
      vx    = sx;
      vy    = sy;
      sq    = vx * vx + vy * vy;
      mag   = floor_root(sq << 16);
      res.x = '0;
      res.y = '0;
      // a dead zone at or past full scale kills the whole range
      if (int'(dz) >= FULL_SCALE || mag == 0 || mag < {dz, 8'd0})
         return res;
      res.x = shrink_axis(vx, mag, dz);
      res.y = shrink_axis(vy, mag, dz);
      return res;
   endfunction

   task automatic send_sample(logic signed [STICK_W-1:0] sx, logic signed [STICK_W-1:0] sy,
                              scaled_pair_type want);
      int gap;
      gap = draw_idle(tx_run, tx_calm);
      if (gap != 0) begin
         if (sender_up) begin
            req_valid <= 1'b0;
            sender_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      if (!sender_up) begin
         req_valid <= 1'b1;
         sender_up = 1'b1;
      end
      req_stick_x <= sx;
      req_stick_y <= sy;
      scaled_due_q.push_back(want);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle_pipeline();
      if (sender_up) begin
         req_valid <= 1'b0;
         sender_up = 1'b0;
      end
      while (scaled_due_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_dead_zone(logic [DZ_W-1:0] dz);
      csr_valid     <= 1'b1;
      csr_dead_zone <= dz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_dz = dz;
   endtask

   // result side: check each beat, then maybe hold ready low for a while
   always @(posedge clock) begin
      scaled_pair_type want;
      int              stall;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scaled_due_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result beat x=%0d y=%0d", rsp_scaled_x, rsp_scaled_y);
            mismatch_count++;
         end else begin
            want = scaled_due_q.pop_front();
            if (rsp_scaled_x !== want.x || rsp_scaled_y !== want.y) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                           want.x, want.y, rsp_scaled_x, rsp_scaled_y);
               mismatch_count++;
            end
         end
         stall = draw_idle(rx_run, rx_calm);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            rx_left   <= stall;
         end
      end else if (rx_left != 0) begin
         rx_left <= rx_left - 1;
         if (rx_left == 1)
            rsp_ready <= 1'b1;
      end
   end

   initial begin
      scaled_pair_type           want;
      logic [DZ_W-1:0]           dz;
      logic signed [STICK_W-1:0] sx;
      logic signed [STICK_W-1:0] sy;
      int                        hi;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_N; i++) begin
         if (probe_tab[i].dz != active_dz) begin
            settle_pipeline();
            write_dead_zone(probe_tab[i].dz);
         end
         sx = probe_tab[i].x;
         sy = probe_tab[i].y;
         if (probe_tab[i].known) begin
            want.x = probe_tab[i].ex;
            want.y = probe_tab[i].ey;
         end else begin
            want = rescale_sample(sx, sy, active_dz);
         end
         send_sample(sx, sy, want);
      end

      for (int phase = 0; phase < PHASE_N; phase++) begin
         unique case (phase)
            0: dz = '0;
            1: dz = 8'd179;
            2: dz = DZ_W'($urandom_range(FULL_SCALE, 255));
            3: dz = DZ_RESET;
            default: dz = DZ_W'($urandom_range(0, FULL_SCALE - 1));
         endcase
         settle_pipeline();
         write_dead_zone(dz);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               // hug the dead zone edge along one axis
               hi = (int'(dz) + 4 > 255) ? 255 : int'(dz) + 4;
               sx = STICK_W'($urandom_range(0, hi));
               sy = STICK_W'($urandom_range(0, 7));
               if ($urandom_range(0, 1) == 1)
                  sx = -sx;
               if ($urandom_range(0, 1) == 1)
                  sy = -sy;
               if ($urandom_range(0, 1) == 1)
                  {sx, sy} = {sy, sx};
            end else begin
               sx = STICK_W'($urandom);
               sy = STICK_W'($urandom);
            end
            send_sample(sx, sy, rescale_sample(sx, sy, active_dz));
         end
      end

      settle_pipeline();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0 && scaled_due_q.size() == 0) begin
         $display("PASS radial_dead_zone_rescale_unit");
      end else begin
         $display("FAIL radial_dead_zone_rescale_unit");
      end
      $finish;
   end

endmodule
